// ===== rtl/psrf_pkg.sv =====
// Shared types, status codes and the wraparound sequence compare for the
// packet sequence receiver filter. No dependencies.
package psrf_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_NOTHING    = 2'd0,
        ST_RECEIVED   = 2'd1,
        ST_UNMATCHING = 2'd2,
        ST_INDEXED    = 2'd3
    } psrf_status_t;

    // Half of the 16-bit sequence space
    localparam logic [15:0] SEQ_HALF = 16'h8000;

    // Event kinds carried by func
    localparam logic FUNC_HEADER   = 1'b0;
    localparam logic FUNC_ACK_SENT = 1'b1;

    // One decoded header item
    typedef struct packed {
        logic        func;
        logic        has_reliable_part;
        logic [15:0] packet_sequence;
        logic [15:0] peer_acked_base;
        logic [31:0] first_index;
        logic [31:0] last_index;
        logic        has_unreliable_part;
        logic [15:0] unreliable_seq_in;
        logic        wants_unrel_ack;
        logic [3:0]  cut_at;
    } psrf_item_t;

    // Receiver state
    typedef struct packed {
        logic        ack_request;
        logic [15:0] last_reliable_seq;
        logic [15:0] last_unreliable_seq;
        logic [31:0] window_first;
        logic [31:0] window_last;
    } psrf_state_t;

    // One result item
    typedef struct packed {
        psrf_status_t       status;
        logic signed [31:0] skip_count;
        logic               ack_pending;
        logic [15:0]        rel_ack_seq;
        logic [15:0]        unrel_ack_seq;
    } psrf_result_t;

    // True when a is more recent than b under wraparound; a distance of
    // exactly half the range counts as newer only when b is numerically larger
    function automatic logic newer16(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = a - b;
        return ((d != 16'd0) && !d[15]) || ((d == SEQ_HALF) && (b > a));
    endfunction

endpackage

// ===== rtl/psrf_header_eval.sv =====
// Combinational evaluation of one header item against the receiver state.
// Depends on psrf_pkg for the item, state and result types.
module psrf_header_eval (
    input  psrf_pkg::psrf_item_t   item,
    input  psrf_pkg::psrf_state_t  state_cur,
    input  logic                   indexing_mode,
    output psrf_pkg::psrf_state_t  state_next,
    output psrf_pkg::psrf_result_t result
);

    logic [3:0]  rel_end;
    logic [3:0]  unrel_end;
    logic        cut_rel;
    logic        cut_unrel;
    logic        is_header;
    logic        rel_newer;
    logic        rel_apply;
    logic        rel_match;
    logic        proceed;
    logic        unrel_newer;
    logic        unrel_apply;
    logic        emit_ok;
    logic [31:0] skip;
    psrf_pkg::psrf_status_t status_rel;

    // Positions of the last reliable field and the last unreliable field
    always_comb begin
        if (item.has_reliable_part) begin
            rel_end = indexing_mode ? 4'd5 : 4'd3;
        end else begin
            rel_end = 4'd1;
        end
        unrel_end = rel_end + (item.has_unreliable_part ? 4'd3 : 4'd1);
    end

    // Locate the cut within the header
    assign cut_rel   = (item.cut_at != 4'd0) && (item.cut_at <= rel_end);
    assign cut_unrel = (item.cut_at > rel_end) && (item.cut_at <= unrel_end);
    assign is_header = (item.func == psrf_pkg::FUNC_HEADER);

    // Reliable section
    assign rel_newer = psrf_pkg::newer16(item.packet_sequence,
                                         state_cur.last_reliable_seq);
    assign rel_apply = is_header && !cut_rel && item.has_reliable_part && rel_newer;
    assign rel_match = indexing_mode
                    || (item.peer_acked_base == state_cur.last_reliable_seq);
    assign proceed   = is_header && !cut_rel && (!item.has_reliable_part || rel_newer);
    assign skip      = state_cur.window_last - item.first_index;

    always_comb begin
        if (!item.has_reliable_part) begin
            status_rel = psrf_pkg::ST_RECEIVED;
        end else if (!rel_match) begin
            status_rel = psrf_pkg::ST_UNMATCHING;
        end else if (indexing_mode) begin
            status_rel = psrf_pkg::ST_INDEXED;
        end else begin
            status_rel = psrf_pkg::ST_RECEIVED;
        end
    end

    // Unreliable section
    assign unrel_newer = psrf_pkg::newer16(item.unreliable_seq_in,
                                           state_cur.last_unreliable_seq);
    assign unrel_apply = proceed && !cut_unrel && item.has_unreliable_part && unrel_newer;
    assign emit_ok     = proceed && !cut_unrel && (!item.has_unreliable_part || unrel_newer);

    // Next state
    always_comb begin
        state_next = state_cur;
        if (!is_header) begin
            state_next.ack_request = 1'b0;
        end else begin
            if (rel_apply) begin
                state_next.ack_request = 1'b1;
                if (rel_match) begin
                    state_next.last_reliable_seq = item.packet_sequence;
                    if (indexing_mode) begin
                        state_next.window_first = item.first_index;
                        state_next.window_last  = item.last_index;
                    end
                end
            end
            if (unrel_apply) begin
                state_next.last_unreliable_seq = item.unreliable_seq_in;
                if (item.wants_unrel_ack) begin
                    state_next.ack_request = 1'b1;
                end
            end
        end
    end

    // Result item, reporting the state after the update
    always_comb begin
        result.status        = emit_ok ? status_rel : psrf_pkg::ST_NOTHING;
        result.skip_count    = (emit_ok && (status_rel == psrf_pkg::ST_INDEXED))
                             ? $signed(skip) : 32'sd0;
        result.ack_pending   = state_next.ack_request;
        result.rel_ack_seq   = state_next.last_reliable_seq;
        result.unrel_ack_seq = state_next.last_unreliable_seq;
    end

endmodule

// ===== rtl/packet_sequence_receiver_filter_unit.sv =====
// Top level of the packet sequence receiver filter: input register, state
// and result register around psrf_header_eval. Depends on psrf_pkg.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready    | decoded header fields, cut_at
//  m_      | out       | m_valid / m_ready    | status, skip_count, acks
//  cfg_    | in        | cfg_valid / cfg_ready| indexing_mode (cfg_data)
//
// One item per cycle sustained while m_ready holds; a result is presented after its item
// has passed through the input register and the result register.
// The state compare and update sits between those two registers and is
// combinational, so consecutive items see each other's updates.
// Reset (synchronous, active low) clears both registers' valid flags, the
// state and indexing_mode. A stalled result holds; the input register still
// takes an item until it is itself full.
module packet_sequence_receiver_filter_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // header items
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic               s_has_reliable_part,
    input  logic [15:0]        s_packet_sequence,
    input  logic [15:0]        s_peer_acked_base,
    input  logic [31:0]        s_first_index,
    input  logic [31:0]        s_last_index,
    input  logic               s_has_unreliable_part,
    input  logic [15:0]        s_unreliable_seq_in,
    input  logic               s_wants_unrel_ack,
    input  logic [3:0]         s_cut_at,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_skip_count,
    output logic               m_ack_pending,
    output logic [15:0]        m_rel_ack_seq,
    output logic [15:0]        m_unrel_ack_seq,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    psrf_pkg::psrf_item_t   item_reg;
    psrf_pkg::psrf_item_t   item_in;
    logic                   item_valid_reg;
    psrf_pkg::psrf_state_t  state_reg;
    psrf_pkg::psrf_state_t  state_next;
    psrf_pkg::psrf_result_t result_reg;
    psrf_pkg::psrf_result_t result_next;
    logic                   result_valid_reg;
    logic                   indexing_mode_reg;
    logic                   advance;

    // Gather the input fields
    always_comb begin
        item_in.func                = s_func;
        item_in.has_reliable_part   = s_has_reliable_part;
        item_in.packet_sequence     = s_packet_sequence;
        item_in.peer_acked_base     = s_peer_acked_base;
        item_in.first_index         = s_first_index;
        item_in.last_index          = s_last_index;
        item_in.has_unreliable_part = s_has_unreliable_part;
        item_in.unreliable_seq_in   = s_unreliable_seq_in;
        item_in.wants_unrel_ack     = s_wants_unrel_ack;
        item_in.cut_at              = s_cut_at;
    end

    // Advance the held item when the result register is free or draining
    assign advance   = item_valid_reg && (!result_valid_reg || m_ready);
    assign s_ready   = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    psrf_header_eval u_eval (
        .item          (item_reg),
        .state_cur     (state_reg),
        .indexing_mode (indexing_mode_reg),
        .state_next    (state_next),
        .result        (result_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_in;
        end
    end

    // State, result register and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= '0;
            result_valid_reg  <= 1'b0;
            indexing_mode_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg        <= state_next;
                result_valid_reg <= 1'b1;
            end else if (m_ready) begin
                result_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                indexing_mode_reg <= cfg_data;
            end
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // Drive the result channel
    assign m_valid         = result_valid_reg;
    assign m_status        = result_reg.status;
    assign m_skip_count    = result_reg.skip_count;
    assign m_ack_pending   = result_reg.ack_pending;
    assign m_rel_ack_seq   = result_reg.rel_ack_seq;
    assign m_unrel_ack_seq = result_reg.unrel_ack_seq;

endmodule

// ===== rtl/psrf_checker.sv =====
// Port-level checks for packet_sequence_receiver_filter_unit, with the bind
// that attaches them. Depends on psrf_pkg for the status codes.
module psrf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [31:0] m_skip_count,
    input logic               m_ack_pending
);

    // Hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
                                && $stable(m_skip_count))
        else $error("stalled result item changed");

    // Skip count only on indexed results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != psrf_pkg::ST_INDEXED) |-> m_skip_count == 32'sd0)
        else $error("skip count set on a non-indexed result");

    // An indexed or unmatching result, from a taken reliable section, carries an ack request
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == psrf_pkg::ST_INDEXED)
                 || (m_status == psrf_pkg::ST_UNMATCHING)) |-> m_ack_pending)
        else $error("reliable section taken without ack request");

    // Drop the result channel during reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind packet_sequence_receiver_filter_unit psrf_checker u_psrf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_skip_count  (m_skip_count),
    .m_ack_pending (m_ack_pending)
);

// ===== sim/tb_packet_sequence_receiver_filter_unit.sv =====
`timescale 1ns / 1ps
// Testbench for packet_sequence_receiver_filter_unit: directed header table, then
// random header traffic in phases with indexing on and off. Depends on psrf_pkg.
module tb_packet_sequence_receiver_filter_unit;

    localparam int          DIR_ROWS    = 28;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 125;
    localparam int unsigned IDLE_LIMIT  = 3000;

    typedef struct {
        logic                   mode;
        psrf_pkg::psrf_item_t   it;
        logic                   pinned;
        psrf_pkg::psrf_result_t want;
    } dir_row_t;

    typedef struct {
        logic                   pinned;
        psrf_pkg::psrf_result_t want;
    } typed_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_func;
    logic               s_has_reliable_part;
    logic [15:0]        s_packet_sequence;
    logic [15:0]        s_peer_acked_base;
    logic [31:0]        s_first_index;
    logic [31:0]        s_last_index;
    logic               s_has_unreliable_part;
    logic [15:0]        s_unreliable_seq_in;
    logic               s_wants_unrel_ack;
    logic [3:0]         s_cut_at;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic signed [31:0] m_skip_count;
    logic               m_ack_pending;
    logic [15:0]        m_rel_ack_seq;
    logic [15:0]        m_unrel_ack_seq;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    // Receiver state as the filter should hold it
    logic               idx_mode;
    logic [15:0]        rel_seq;
    logic [15:0]        unrel_seq;
    logic [31:0]        win_first;
    logic [31:0]        win_last;
    logic               ack_req;

    psrf_pkg::psrf_result_t due_results[$];
    typed_result_t          typed_results[$];
    dir_row_t               dir[DIR_ROWS];
    int                     errors = 0;
    int unsigned            idle_cycles;
    logic                   calm;

    packet_sequence_receiver_filter_unit uut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_func                (s_func),
        .s_has_reliable_part   (s_has_reliable_part),
        .s_packet_sequence     (s_packet_sequence),
        .s_peer_acked_base     (s_peer_acked_base),
        .s_first_index         (s_first_index),
        .s_last_index          (s_last_index),
        .s_has_unreliable_part (s_has_unreliable_part),
        .s_unreliable_seq_in   (s_unreliable_seq_in),
        .s_wants_unrel_ack     (s_wants_unrel_ack),
        .s_cut_at              (s_cut_at),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_skip_count          (m_skip_count),
        .m_ack_pending         (m_ack_pending),
        .m_rel_ack_seq         (m_rel_ack_seq),
        .m_unrel_ack_seq       (m_unrel_ack_seq),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data)
    );

    function automatic psrf_pkg::psrf_item_t hdr(input logic f, input logic hr,
                                       input logic [15:0] seq, input logic [15:0] base,
                                       input logic [31:0] first, input logic [31:0] last,
                                       input logic hu, input logic [15:0] useq,
                                       input logic wack, input logic [3:0] cut);
        psrf_pkg::psrf_item_t it;
        it.func                = f;
        it.has_reliable_part   = hr;
        it.packet_sequence     = seq;
        it.peer_acked_base     = base;
        it.first_index         = first;
        it.last_index          = last;
        it.has_unreliable_part = hu;
        it.unreliable_seq_in   = useq;
        it.wants_unrel_ack     = wack;
        it.cut_at              = cut;
        return it;
    endfunction

    function automatic psrf_pkg::psrf_result_t res(input psrf_pkg::psrf_status_t st,
                                         input logic [31:0] skip,
                                         input logic ack, input logic [15:0] rel,
                                         input logic [15:0] unrel);
        psrf_pkg::psrf_result_t r;
        r.status        = st;
        r.skip_count    = skip;
        r.ack_pending   = ack;
        r.rel_ack_seq   = rel;
        r.unrel_ack_seq = unrel;
        return r;
    endfunction

    // Wraparound recency: a is newer when ahead of b by less than half the space,
    // or by exactly half when it sits numerically below b
    function automatic logic seq_after(input logic [15:0] a, input logic [15:0] b);
        int unsigned ua;
        int unsigned ub;
        ua = 32'(a);
        ub = 32'(b);
        return (ua > ub && ua - ub <= 32767) || (ub > ua && ub - ua > 32767);
    endfunction

    function automatic psrf_pkg::psrf_result_t snapshot(input psrf_pkg::psrf_status_t st,
                                                        input logic [31:0] skip);
        return res(st, (st == psrf_pkg::ST_INDEXED) ? skip : 32'd0,
                   ack_req, rel_seq, unrel_seq);
    endfunction

    // Apply one header or ack-sent event to the state and return its result
    function automatic psrf_pkg::psrf_result_t filter_header(input psrf_pkg::psrf_item_t it);
        int unsigned            cut;
        int unsigned            n_rel;
        int unsigned            u_pos;
        psrf_pkg::psrf_status_t st;
        logic [31:0]            skip;
        cut  = 32'(it.cut_at);
        st   = psrf_pkg::ST_RECEIVED;
        skip = 32'd0;
        if (it.func == psrf_pkg::FUNC_ACK_SENT) begin
            ack_req = 1'b0;
            return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
        end
        // fields read up to the unreliable flag
        n_rel = it.has_reliable_part ? (idx_mode ? 4 : 2) : 0;
        if (cut >= 1 && cut <= 1 + n_rel)
            return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
        if (it.has_reliable_part) begin
            if (!seq_after(it.packet_sequence, rel_seq))
                return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
            ack_req = 1'b1;
            if (idx_mode) begin
                rel_seq   = it.packet_sequence;
                skip      = win_last - it.first_index;
                win_first = it.first_index;
                win_last  = it.last_index;
                st        = psrf_pkg::ST_INDEXED;
            end else if (it.peer_acked_base == rel_seq) begin
                rel_seq = it.packet_sequence;
            end else begin
                st = psrf_pkg::ST_UNMATCHING;
            end
        end
        u_pos = 2 + n_rel;
        if (cut == u_pos)
            return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
        if (it.has_unreliable_part) begin
            if (cut == u_pos + 1 || cut == u_pos + 2)
                return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
            if (!seq_after(it.unreliable_seq_in, unrel_seq))
                return snapshot(psrf_pkg::ST_NOTHING, 32'd0);
            unrel_seq = it.unreliable_seq_in;
            if (it.wants_unrel_ack)
                ack_req = 1'b1;
        end
        return snapshot(st, skip);
    endfunction

    function automatic int unsigned pause_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input psrf_pkg::psrf_item_t it, input logic pinned,
                             input psrf_pkg::psrf_result_t want);
        int unsigned   gap;
        typed_result_t entry;
        gap = pause_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        entry.pinned  = pinned;
        entry.want    = want;
        typed_results = {typed_results, entry};
        s_func                <= it.func;
        s_has_reliable_part   <= it.has_reliable_part;
        s_packet_sequence     <= it.packet_sequence;
        s_peer_acked_base     <= it.peer_acked_base;
        s_first_index         <= it.first_index;
        s_last_index          <= it.last_index;
        s_has_unreliable_part <= it.has_unreliable_part;
        s_unreliable_seq_in   <= it.unreliable_seq_in;
        s_wants_unrel_ack     <= it.wants_unrel_ack;
        s_cut_at              <= it.cut_at;
        s_valid               <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drain the filter, then write indexing_mode
    task automatic set_indexing(input logic mode);
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_data  <= mode;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: bursts of ready broken by stalls
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            int unsigned len;
            len = $urandom_range(1, 16);
            m_ready <= 1'b1;
            repeat (len) @(negedge aclk);
            len = pause_len();
            if (len != 0) begin
                m_ready <= 1'b0;
                repeat (len) @(negedge aclk);
            end
        end
    end

    // Track config and state, check each result against the oldest expectation
    always @(posedge aclk) begin
        psrf_pkg::psrf_result_t want;
        psrf_pkg::psrf_result_t pred;
        typed_result_t          typed;
        if (!aresetn) begin
            idx_mode  = 1'b0;
            rel_seq   = 16'd0;
            unrel_seq = 16'd0;
            win_first = 32'd0;
            win_last  = 32'd0;
            ack_req   = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result item with nothing expected");
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(m_status));
                    compare_field("skip_count", want.skip_count, m_skip_count);
                    compare_field("ack_pending", 32'(want.ack_pending),
                                  32'(m_ack_pending));
                    compare_field("rel_ack_seq", 32'(want.rel_ack_seq),
                                  32'(m_rel_ack_seq));
                    compare_field("unrel_ack_seq", 32'(want.unrel_ack_seq),
                                  32'(m_unrel_ack_seq));
                end
            end
            if (s_valid && s_ready) begin
                pred  = filter_header(hdr(s_func, s_has_reliable_part, s_packet_sequence,
                                          s_peer_acked_base, s_first_index, s_last_index,
                                          s_has_unreliable_part, s_unreliable_seq_in,
                                          s_wants_unrel_ack, s_cut_at));
                typed = typed_results.pop_front();
                due_results = {due_results, (typed.pinned ? typed.want : pred)};
            end
            if (cfg_valid && cfg_ready)
                idx_mode = cfg_data;
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("packet_sequence_receiver_filter_unit verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus
    initial begin
        psrf_pkg::psrf_item_t   it;
        psrf_pkg::psrf_result_t none;
        logic                   cur_mode;
        int unsigned            r;
        int unsigned            pick;
        calm                  = 1'b0;
        none                  = '0;
        aresetn               = 1'b0;
        s_valid               = 1'b0;
        s_func                = psrf_pkg::FUNC_HEADER;
        s_has_reliable_part   = 1'b0;
        s_packet_sequence     = 16'd0;
        s_peer_acked_base     = 16'd0;
        s_first_index         = 32'd0;
        s_last_index          = 32'd0;
        s_has_unreliable_part = 1'b0;
        s_unreliable_seq_in   = 16'd0;
        s_wants_unrel_ack     = 1'b0;
        s_cut_at              = 4'd0;
        cfg_valid             = 1'b0;
        cfg_data              = 1'b0;

        // Directed rows; expectations typed in only for the first few
        dir[0]  = '{1'b0, hdr(psrf_pkg::FUNC_ACK_SENT, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1, 16'hFFFF, 1, 4'hF),
                    1'b1, res(psrf_pkg::ST_NOTHING, 32'd0, 1'b0, 16'h0000, 16'h0000)};
        dir[1]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0001, 16'h0000, 0, 0, 0, 0, 0, 0),
                    1'b1, res(psrf_pkg::ST_RECEIVED, 32'd0, 1'b1, 16'h0001, 16'h0000)};
        dir[2]  = '{1'b0, hdr(psrf_pkg::FUNC_ACK_SENT, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                    1'b1, res(psrf_pkg::ST_NOTHING, 32'd0, 1'b0, 16'h0001, 16'h0000)};
        dir[3]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0001, 16'h0001, 0, 0, 0, 0, 0, 0),
                    1'b1, res(psrf_pkg::ST_NOTHING, 32'd0, 1'b0, 16'h0001, 16'h0000)};
        // half the space ahead is stale, one less is fresh
        dir[4]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h8001, 16'h0001, 0, 0, 0, 0, 0, 0),
                    0, none};
        dir[5]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h8000, 16'h0001, 0, 0, 0, 0, 0, 0),
                    0, none};
        // base does not match
        dir[6]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'hFFFF, 16'h1234, 0, 0, 0, 0, 0, 0),
                    0, none};
        dir[7]  = '{1'b0, hdr(psrf_pkg::FUNC_ACK_SENT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none};
        // unreliable only: stale, fresh, stale at half space, fresh with ack
        dir[8]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'hFFFF, 1, 0),
                    0, none};
        dir[9]  = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'h7FFF, 0, 0),
                    0, none};
        dir[10] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'hFFFF, 1, 0),
                    0, none};
        dir[11] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'hFFFE, 1, 0),
                    0, none};
        dir[12] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none};
        // cuts inside the reliable section
        dir[13] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h8001, 16'h8000, 0, 0, 0, 0, 0, 1),
                    0, none};
        dir[14] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h8001, 16'h8000, 0, 0, 0, 0, 0, 2),
                    0, none};
        dir[15] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h8001, 16'h8000, 0, 0, 0, 0, 0, 3),
                    0, none};
        // cuts after the reliable update keep it
        dir[16] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0000, 16'h8000, 0, 0, 0, 0, 0, 4),
                    0, none};
        dir[17] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0001, 16'h0000, 0, 0,
                              1, 16'hFFFF, 1, 6), 0, none};
        // cuts beyond the header, then one inside the unreliable section
        dir[18] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'h0005, 1, 5),
                    0, none};
        dir[19] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0002, 16'h0001, 0, 0,
                              1, 16'h0006, 0, 4'hF), 0, none};
        dir[20] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 0, 0, 0, 0, 0, 1, 16'h0007, 0, 3),
                    0, none};
        // stale reliable hides a fresh unreliable part; an unmatching one does not
        dir[21] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0002, 16'h0002, 0, 0,
                              1, 16'h0008, 1, 0), 0, none};
        dir[22] = '{1'b0, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0003, 16'h7777, 0, 0,
                              1, 16'h0008, 1, 0), 0, none};
        // indexing: skip of one, minus one, cut at last index, minimum, cut late
        dir[23] = '{1'b1, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0004, 16'hAAAA, 32'hFFFF_FFFF,
                              32'h0, 0, 0, 0, 0), 0, none};
        dir[24] = '{1'b1, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0005, 16'h0000, 32'h1,
                              32'h8000_0000, 0, 0, 0, 0), 0, none};
        dir[25] = '{1'b1, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0006, 16'h0000, 32'h0, 32'h0,
                              0, 0, 0, 5), 0, none};
        dir[26] = '{1'b1, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0006, 16'h0000, 32'h0,
                              32'h7FFF_FFFF, 1, 16'h0009, 1, 0), 0, none};
        dir[27] = '{1'b1, hdr(psrf_pkg::FUNC_HEADER, 1, 16'h0007, 16'h0000, 32'h5, 32'h9,
                              1, 16'h000A, 1, 7), 0, none};

        // Hold reset, then start with indexing off
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        set_indexing(1'b0);
        cur_mode = 1'b0;

        foreach (dir[i]) begin
            if (dir[i].mode != cur_mode) begin
                set_indexing(dir[i].mode);
                cur_mode = dir[i].mode;
            end
            send_item(dir[i].it, dir[i].pinned, dir[i].want);
        end

        // Random phases, alternating indexing mode; two phases without gaps
        for (int ph = 0; ph < PHASES; ph++) begin
            set_indexing(ph[0] ? 1'b0 : 1'b1);
            calm = (ph == 3 || ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                it = hdr(psrf_pkg::FUNC_HEADER, 1'($urandom), 16'($urandom), 16'($urandom),
                         32'($urandom), 32'($urandom), 1'($urandom), 16'($urandom),
                         1'($urandom), 4'($urandom));
                r = $urandom_range(99);
                if (r < 8) begin
                    it.func = psrf_pkg::FUNC_ACK_SENT;
                end else if (r >= 20) begin
                    // well-formed header close to the current sequence numbers
                    it.has_reliable_part = ($urandom_range(9) < 8);
                    pick = $urandom_range(19);
                    if (pick < 14)
                        it.packet_sequence = rel_seq + 16'($urandom_range(1, 3));
                    else if (pick < 17)
                        it.packet_sequence = rel_seq - 16'($urandom_range(0, 3));
                    else if (pick == 17)
                        it.packet_sequence = rel_seq + 16'h7FFF;
                    else if (pick == 18)
                        it.packet_sequence = rel_seq + 16'h8000;
                    if ($urandom_range(9) < 8)
                        it.peer_acked_base = rel_seq;
                    if ($urandom_range(3) != 0) begin
                        it.first_index = win_last + 32'($urandom_range(0, 4)) - 32'd2;
                        it.last_index  = it.first_index + 32'($urandom_range(0, 20));
                    end
                    it.has_unreliable_part = ($urandom_range(9) < 7);
                    pick = $urandom_range(9);
                    if (pick < 7)
                        it.unreliable_seq_in = unrel_seq + 16'($urandom_range(1, 3));
                    else if (pick < 9)
                        it.unreliable_seq_in = unrel_seq - 16'($urandom_range(0, 3));
                    it.cut_at = ($urandom_range(9) < 8) ? 4'd0 : 4'($urandom_range(1, 8));
                end
                send_item(it, 1'b0, none);
            end
        end
        calm = 1'b0;

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        while (due_results.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (errors == 0)
            $display("packet_sequence_receiver_filter_unit verification clean");
        else
            $display("packet_sequence_receiver_filter_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psrf_pkg.sv
rtl/psrf_header_eval.sv
rtl/packet_sequence_receiver_filter_unit.sv
rtl/psrf_checker.sv
sim/tb_packet_sequence_receiver_filter_unit.sv
